/* rtl/long_press_blink_controller_unit_macros.svh */
// Assertion macros used by the long-press blink controller core.
`ifndef LONG_PRESS_BLINK_CONTROLLER_UNIT_MACROS_SVH
`define LONG_PRESS_BLINK_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpbc assertion failed");

// Next-cycle implication, checked outside reset.
`define LPBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpbc assertion failed");

`endif

/* rtl/lpbc_pkg.sv */
// Types, constants and helper functions of the long-press blink controller.
package lpbc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 3;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd50;
  localparam logic [CFG_W-1:0] BLINK_LENGTH_RST = 16'd1000;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RST  = 16'd10;

  // Mode codes on the result channel
  localparam logic [MODE_W-1:0] MODE_IDLE           = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRESSING       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK_HELD     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLINKING       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CANCEL_PRESS   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CANCEL_WAIT    = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE         = 6'b000001,
    ST_PRESSING     = 6'b000010,
    ST_BLINK_HELD   = 6'b000100,
    ST_BLINKING     = 6'b001000,
    ST_CANCEL_PRESS = 6'b010000,
    ST_CANCEL_WAIT  = 6'b100000
  } lpbc_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] blink_length;
    logic [CFG_W-1:0] half_period;
  } lpbc_cfg_t;

  // Increment a tick counter, holding at full scale
  function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] t);
    return (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

  // True once a counter has reached its limit
  function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                   input logic [CFG_W-1:0] lim);
    return CMP_W'(t) >= CMP_W'(lim);
  endfunction

  // Map a state to its external mode code
  function automatic logic [MODE_W-1:0] mode_of(input lpbc_state_t st);
    logic [MODE_W-1:0] m;
    unique case (st)
      ST_PRESSING:     m = MODE_PRESSING;
      ST_BLINK_HELD:   m = MODE_BLINK_HELD;
      ST_BLINKING:     m = MODE_BLINKING;
      ST_CANCEL_PRESS: m = MODE_CANCEL_PRESS;
      ST_CANCEL_WAIT:  m = MODE_CANCEL_WAIT;
      default:         m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

/* rtl/lpbc_cfg_regs.sv */
// Configuration register file of the long-press blink controller.
module lpbc_cfg_regs import lpbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output lpbc_cfg_t            cfg
);

  lpbc_cfg_t cfg_r;
  lpbc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the write; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LONG_PRESS:   cfg_nxt.long_press   = cfg_data;
        REG_BLINK_LENGTH: cfg_nxt.blink_length = cfg_data;
        REG_HALF_PERIOD:  cfg_nxt.half_period  = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press   <= LONG_PRESS_RST;
      cfg_r.blink_length <= BLINK_LENGTH_RST;
      cfg_r.half_period  <= HALF_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/lpbc_core.sv */
// Press-timing state machine, tick counters and LED level.
`include "long_press_blink_controller_unit_macros.svh"

module lpbc_core import lpbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              button,
  input  lpbc_cfg_t         cfg,
  output logic              led_nxt,
  output logic [MODE_W-1:0] mode_nxt
);

  lpbc_state_t           state_r, state_nxt;
  logic [TIMER_BITS-1:0] press_timer_r, press_timer_nxt;
  logic [TIMER_BITS-1:0] blink_timer_r, blink_timer_nxt;
  logic [TIMER_BITS-1:0] toggle_timer_r, toggle_timer_nxt;
  logic                  led_r, led_tick;

  logic [TIMER_BITS-1:0] press_b, blink_b, toggle_b;
  logic                  toggle_due;

  assign press_b    = bump(press_timer_r);
  assign blink_b    = bump(blink_timer_r);
  assign toggle_b   = bump(toggle_timer_r);
  assign toggle_due = reached(toggle_b, cfg.half_period);

  // Work out the state after one tick
  always_comb begin
    state_nxt        = state_r;
    press_timer_nxt  = press_b;
    blink_timer_nxt  = blink_b;
    toggle_timer_nxt = toggle_b;
    led_tick         = led_r;
    unique case (state_r)
      ST_PRESSING: begin
        if (!button) begin
          state_nxt = ST_IDLE;
        end else if (reached(press_b, cfg.long_press)) begin
          state_nxt        = ST_BLINK_HELD;
          blink_timer_nxt  = '0;
          toggle_timer_nxt = '0;
          led_tick         = 1'b1;
        end
      end
      ST_BLINK_HELD: begin
        if (reached(blink_b, cfg.blink_length)) begin
          state_nxt = ST_IDLE;
          led_tick  = 1'b0;
        end else if (!button) begin
          state_nxt = ST_BLINKING;
        end else if (toggle_due) begin
          led_tick         = ~led_r;
          toggle_timer_nxt = '0;
        end
      end
      ST_BLINKING: begin
        if (button) begin
          state_nxt       = ST_CANCEL_PRESS;
          press_timer_nxt = '0;
        end else if (reached(blink_b, cfg.blink_length)) begin
          state_nxt = ST_IDLE;
          led_tick  = 1'b0;
        end else if (toggle_due) begin
          led_tick         = ~led_r;
          toggle_timer_nxt = '0;
        end
      end
      ST_CANCEL_PRESS: begin
        // blink length is not checked while the cancel press is timed
        if (!button) begin
          state_nxt = ST_BLINKING;
        end else if (reached(press_b, cfg.long_press)) begin
          state_nxt = ST_CANCEL_WAIT;
        end else if (toggle_due) begin
          led_tick         = ~led_r;
          toggle_timer_nxt = '0;
        end
      end
      ST_CANCEL_WAIT: begin
        // LED stays frozen until release
        if (!button) begin
          state_nxt = ST_IDLE;
          led_tick  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        if (button) begin
          state_nxt       = ST_PRESSING;
          press_timer_nxt = '0;
        end
      end
    endcase
  end

  assign led_nxt  = led_tick;
  assign mode_nxt = mode_of(state_nxt);

  // Commit the tick when an item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      press_timer_r  <= '0;
      blink_timer_r  <= '0;
      toggle_timer_r <= '0;
      led_r          <= 1'b0;
    end else if (step) begin
      state_r        <= state_nxt;
      press_timer_r  <= press_timer_nxt;
      blink_timer_r  <= blink_timer_nxt;
      toggle_timer_r <= toggle_timer_nxt;
      led_r          <= led_tick;
    end
  end

  `LPBC_ASSERT_NOW(a_idle_led_off, state_r == ST_IDLE, !led_r)
  `LPBC_ASSERT_NEXT(a_cancel_wait_frozen,
                    step && state_r == ST_CANCEL_WAIT && button,
                    led_r == $past(led_r) && state_r == ST_CANCEL_WAIT)
  `LPBC_ASSERT_NEXT(a_blink_start,
                    step && state_r == ST_PRESSING && state_nxt == ST_BLINK_HELD,
                    led_r && blink_timer_r == '0 && toggle_timer_r == '0)

endmodule

/* rtl/long_press_blink_controller_unit.sv */
// Top level of the long-press blink controller: channel registers and submodules.
//
// One button sample enters per item and exactly one result leaves for it,
// carrying the LED level and mode after that tick. The block accepts one item
// every clock cycle while in_stall is low. An accepted item waits in the input
// register, where the counter compare-and-increment and the state decision
// are done, and its result is then written into the result register when
// no finished result is held back there. A stalled result holds while the
// input register can still take one more item. Configuration writes are
// always ready and take effect on the next tick processed.
module long_press_blink_controller_unit import lpbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_button,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_led,
  output logic [MODE_W-1:0]    out_mode,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  lpbc_cfg_t         cfg;
  logic              s1_valid_r, s1_button_r;
  logic              out_valid_r, out_led_r;
  logic [MODE_W-1:0] out_mode_r;
  logic              advance, step, led_nxt;
  logic [MODE_W-1:0] mode_nxt;

  lpbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpbc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .button   (s1_button_r),
    .cfg      (cfg),
    .led_nxt  (led_nxt),
    .mode_nxt (mode_nxt)
  );

  // Move forward unless a finished result is held back
  assign advance  = !(out_valid_r && out_stall);
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_button_r <= in_button;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_led_r  <= led_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_led   = out_led_r;
  assign out_mode  = out_mode_r;

endmodule
